[hw/rtl/ssid_pkg.sv]
`default_nettype none

package ssid_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic step;
      logic insert;
      logic remove;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_last;
      logic hit;
      logic full;
   } flags_type;

endpackage

`default_nettype wire

[hw/rtl/ssid_cells.sv]
`default_nettype none

module ssid_cells
   import ssid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cmd_type                          cmd,
   input  wire logic signed [VALUE_W-1:0]        key,
   output      flags_type                        flags,
   output      logic [$clog2(CAPACITY+1)-1:0]    pos,
   output      logic [$clog2(CAPACITY+1)-1:0]    count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int BIT_W = $clog2(CNT_W);

   logic signed [VALUE_W-1:0] key_ff;
   logic signed [VALUE_W-1:0] cell_ff [CAPACITY];
   logic [CAPACITY-1:0]       lt_ff;
   logic [CAPACITY-1:0]       eq_ff;
   logic [CNT_W-1:0]          pos_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [BIT_W-1:0]          bit_ff;

   logic [CNT_W-1:0] trial;
   logic             trial_ok;
   logic [IDX_W-1:0] trial_idx;
   logic [IDX_W-1:0] pos_idx;

   // less-than flags form a thermometer, so search it one result bit a cycle
   assign trial     = pos_ff | (CNT_W'(1) << bit_ff);
   assign trial_ok  = trial <= CNT_W'(CAPACITY);
   assign trial_idx = IDX_W'(trial - CNT_W'(1));
   assign pos_idx   = IDX_W'(pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= key;
         pos_ff <= '0;
         bit_ff <= BIT_W'(CNT_W - 1);
      end else if (cmd.step) begin
         if (trial_ok && lt_ff[trial_idx]) begin
            pos_ff <= trial;
         end
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] below;
      logic signed [VALUE_W-1:0] above;
      logic                      valid;

      if (g == 0) begin : g_first
         assign below = key_ff;
      end else begin : g_mid_lo
         assign below = cell_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign above = cell_ff[g];
      end else begin : g_mid_hi
         assign above = cell_ff[g+1];
      end

      assign valid = CNT_W'(g) < count_ff;

      always_ff @(posedge clock) begin
         if (cmd.compare) begin
            lt_ff[g] <= valid && (cell_ff[g] < key_ff);
            eq_ff[g] <= valid && (cell_ff[g] == key_ff);
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.insert) begin
            if (CNT_W'(g) == pos_ff) begin
               cell_ff[g] <= key_ff;
            end else if (CNT_W'(g) > pos_ff) begin
               cell_ff[g] <= below;
            end
         end else if (cmd.remove) begin
            if (CNT_W'(g) >= pos_ff) begin
               cell_ff[g] <= above;
            end
         end
      end
   end

   always_comb begin
      flags.search_last = bit_ff == '0;
      flags.hit         = (pos_ff < CNT_W'(CAPACITY)) && eq_ff[pos_idx];
      flags.full        = count_ff == CNT_W'(CAPACITY);
   end

   assign pos   = pos_ff;
   assign count = count_ff;

endmodule

`default_nettype wire

[hw/rtl/ssid_ctrl.sv]
`default_nettype none

module ssid_ctrl
   import ssid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_op,
   output      logic                          req_stall,
   output      cmd_type                       cmd,
   input  wire flags_type                     flags,
   input  wire logic [$clog2(CAPACITY+1)-1:0] pos,
   input  wire logic [$clog2(CAPACITY+1)-1:0] count,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      rsp_type                       rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_COMMIT
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic                op_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                out_free;
   logic                commit;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    count_after;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == S_COMMIT) && out_free;

   always_comb begin
      cmd.load    = (state_ff == S_IDLE) && req_valid;
      cmd.compare = state_ff == S_COMPARE;
      cmd.step    = state_ff == S_SEARCH;
      cmd.insert  = commit && (op_ff == OP_INSERT) && !flags.hit && !flags.full;
      cmd.remove  = commit && (op_ff == OP_DELETE) && flags.hit;
   end

   always_comb begin
      if (op_ff == OP_INSERT) begin
         if (flags.hit) begin
            status = ST_DUPLICATE;
         end else if (flags.full) begin
            status = ST_FULL;
         end else begin
            status = ST_INSERTED;
         end
      end else begin
         status = flags.hit ? ST_DELETED : ST_NOT_FOUND;
      end

      if (cmd.insert) begin
         count_after = count + CNT_W'(1);
      end else if (cmd.remove) begin
         count_after = count - CNT_W'(1);
      end else begin
         count_after = count;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (flags.search_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load) begin
            op_ff <= req_op;
         end
         // hold the word until taken; load the next one on commit
         if (commit) begin
            rsp_valid_ff    <= 1'b1;
            rsp_ff.status   <= status;
            rsp_ff.position <= POSITION_W'(pos);
            rsp_ff.count    <= COUNT_W'(count_after);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/sorted_set_insert_delete_core.sv]
// Sorted set of distinct signed 32-bit values, held in ascending order in a
// row of CAPACITY cells.
// Request channel (req_valid, req_stall, req_data): each word asks to insert
// (op 0) or delete (op 1) one value. Response channel (rsp_valid, rsp_stall,
// rsp_data): one word per request with status, sorted position and the count
// after the operation.
// Every cell compares with the value at once; the position is then read
// off the compare flags one bit a cycle, and the cells then shift when the
// request commits, once the output register is free. The next request is
// accepted the cycle after the commit.
// req_stall is high while a request is in flight. The response sits in an
// output register, so a new request is taken while an earlier response
// waits; if the receiver stalls, the next commit waits for the register.
// Reset empties the set and drops any pending response; no clearing pass.
`default_nettype none

module sorted_set_insert_delete_core
   import ssid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type          cmd;
   flags_type        flags;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] count;

   ssid_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.op),
      .req_stall(req_stall),
      .cmd      (cmd),
      .flags    (flags),
      .pos      (pos),
      .count    (count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   ssid_cells #(
      .CAPACITY(CAPACITY)
   ) u_cells (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .key  (req_data.value),
      .flags(flags),
      .pos  (pos),
      .count(count)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count <= CNT_W'(CAPACITY))
      else $error("stored count exceeds capacity");

   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.compare, cmd.step, cmd.insert, cmd.remove}))
      else $error("more than one datapath command at once");

   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a request in flight");

   a_full_no_insert : assert property (@(posedge clock) disable iff (reset)
      flags.full |-> !cmd.insert)
      else $error("insert issued into a full set");

endmodule

`default_nettype wire
